// ----- hw/rtl/lruc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_pkg: shared definitions for the LRU key-value cache
// Field widths, command codes, register defaults and the store write bundle.
// ----------------------------------------------------------------------------
package lruc_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 4;
    localparam int DEFAULT_ENTRIES = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    typedef struct packed {
        logic             key_we;
        logic             val_we;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } wr_t;

endpackage
`default_nettype wire

// ----- hw/rtl/lruc_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lruc_store: key and value memories
// One registered read port and one write port, shared by keys and values.
// ----------------------------------------------------------------------------
module lruc_store #(
    parameter int ENTRIES = lruc_pkg::DEFAULT_ENTRIES
) (
    input  wire                                            clk,
    input  wire  [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] raddr,
    output logic [lruc_pkg::KEY_W-1:0]                     rd_key,
    output logic [lruc_pkg::VAL_W-1:0]                     rd_value,
    input  wire  [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] waddr,
    input  lruc_pkg::wr_t                                  wr
);

    logic [lruc_pkg::KEY_W-1:0] key_mem [ENTRIES];
    logic [lruc_pkg::VAL_W-1:0] val_mem [ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[waddr] <= wr.key;
        end
        if (wr.val_we)
        begin
            val_mem[waddr] <= wr.value;
        end
        rd_key   <= key_mem[raddr];
        rd_value <= val_mem[raddr];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/lru_key_value_cache_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache_top: fully associative key-value cache, LRU replacement
// A get or put transaction is taken when start is high and busy is low. The
// key is compared against one stored entry per cycle through a single
// comparator fed by the key memory read port; the same pass finds the least
// recent entry and the lowest free slot. Busy stays high from the accepting
// edge through the scan over all entries, the read latency drain state and
// the write-back state. Done is high in the following cycle, when busy is
// already low, so a new transaction can be taken while done is high.
// The result is on the output ports while done is high for one cycle; the
// receiver cannot stall it, so capture it then. A capacity write clears the
// store and is taken only while idle.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
    parameter int ENTRIES = lruc_pkg::DEFAULT_ENTRIES
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               command,
    input  wire  signed [lruc_pkg::KEY_W-1:0] key,
    input  wire  signed [lruc_pkg::VAL_W-1:0] value,
    output logic                              done,
    output logic                              hit,
    output logic signed [lruc_pkg::VAL_W-1:0] read_value,
    output logic                              evicted,
    output logic signed [lruc_pkg::KEY_W-1:0] evicted_key,
    output logic                              ignored,
    input  wire                               cfg_valid,
    output logic                              cfg_ready,
    input  wire  [lruc_pkg::CAP_W-1:0]        cfg_data
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [IDX_W-1:0]           scan_reg;
    logic                       q_live_reg;
    logic [IDX_W-1:0]           q_idx_reg;

    logic                       cmd_reg;
    logic [lruc_pkg::KEY_W-1:0] key_reg;
    logic [lruc_pkg::VAL_W-1:0] val_reg;

    logic                       have_reg;
    logic [IDX_W-1:0]           found_reg;
    logic [lruc_pkg::VAL_W-1:0] found_val_reg;
    logic [IDX_W-1:0]           old_idx_reg;
    logic [lruc_pkg::KEY_W-1:0] old_key_reg;
    logic                       free_have_reg;
    logic [IDX_W-1:0]           free_idx_reg;

    logic [lruc_pkg::CAP_W-1:0] capacity_reg;
    logic [ENTRIES-1:0]         valid_reg, valid_next;
    logic [IDX_W-1:0]           rank_reg  [ENTRIES];
    logic [IDX_W-1:0]           rank_next [ENTRIES];
    logic [CNT_W-1:0]           occupancy_reg, occupancy_next;

    logic                       done_reg;
    logic                       hit_reg, hit_next;
    logic [lruc_pkg::VAL_W-1:0] rd_reg, rd_next;
    logic                       ev_reg, ev_next;
    logic [lruc_pkg::KEY_W-1:0] evk_reg, evk_next;
    logic                       ign_reg, ign_next;

    logic [lruc_pkg::KEY_W-1:0] rd_key;
    logic [lruc_pkg::VAL_W-1:0] rd_value;
    logic [IDX_W-1:0]           waddr;
    lruc_pkg::wr_t              wr;

    logic                       accept;
    logic                       cfg_write;
    logic [CNT_W-1:0]           cap_eff;
    logic                       match;
    logic                       is_old;
    logic                       is_free;
    logic                       evict;
    logic [IDX_W-1:0]           slot;
    logic [IDX_W-1:0]           promo_rank;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb
    begin
        if (32'(capacity_reg) > ENTRIES)
        begin
            cap_eff = CNT_W'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_W'(capacity_reg);
        end
    end

    lruc_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .raddr    (scan_reg),
        .rd_key   (rd_key),
        .rd_value (rd_value),
        .waddr    (waddr),
        .wr       (wr)
    );

    // shared comparator: one stored entry per cycle
    assign match   = q_live_reg && valid_reg[q_idx_reg] && (rd_key == key_reg);
    assign is_old  = q_live_reg && valid_reg[q_idx_reg] &&
                     (rank_reg[q_idx_reg] == IDX_W'(occupancy_reg - CNT_W'(1)));
    assign is_free = q_live_reg && !valid_reg[q_idx_reg];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign evict = (occupancy_reg >= cap_eff);
    assign promo_rank = rank_reg[found_reg];

    always_comb
    begin
        if (evict && !(free_have_reg && (free_idx_reg < old_idx_reg)))
        begin
            slot = old_idx_reg;
        end
        else
        begin
            slot = free_idx_reg;
        end
    end

    // write-back decision
    always_comb
    begin
        valid_next     = valid_reg;
        rank_next      = rank_reg;
        occupancy_next = occupancy_reg;
        hit_next       = 1'b0;
        rd_next        = '0;
        ev_next        = 1'b0;
        evk_next       = '0;
        ign_next       = 1'b0;
        waddr          = found_reg;
        wr.key_we      = 1'b0;
        wr.val_we      = 1'b0;
        wr.key         = key_reg;
        wr.value       = val_reg;
        if (state_reg == ST_FIN)
        begin
            if (cmd_reg == lruc_pkg::CMD_PUT && cap_eff == '0)
            begin
                ign_next = 1'b1;
            end
            else if (have_reg)
            begin
                hit_next = 1'b1;
                if (cmd_reg == lruc_pkg::CMD_GET)
                begin
                    rd_next = found_val_reg;
                end
                else
                begin
                    wr.val_we = 1'b1;
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < promo_rank)
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[found_reg] = '0;
            end
            else if (cmd_reg == lruc_pkg::CMD_PUT)
            begin
                if (evict)
                begin
                    ev_next                 = 1'b1;
                    evk_next                = old_key_reg;
                    valid_next[old_idx_reg] = 1'b0;
                    rank_next[old_idx_reg]  = '0;
                end
                else
                begin
                    occupancy_next = occupancy_reg + CNT_W'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_next[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                valid_next[slot] = 1'b1;
                rank_next[slot]  = '0;
                waddr            = slot;
                wr.key_we        = 1'b1;
                wr.val_we        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_reg      <= '0;
            q_live_reg    <= 1'b0;
            have_reg      <= 1'b0;
            free_have_reg <= 1'b0;
            capacity_reg  <= lruc_pkg::CAP_RESET;
            valid_reg     <= '0;
            occupancy_reg <= '0;
            done_reg      <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            q_live_reg <= (state_reg == ST_SCAN);
            done_reg   <= (state_reg == ST_FIN);
            if (state_reg == ST_SCAN)
            begin
                scan_reg <= scan_reg + IDX_W'(1);
            end
            else
            begin
                scan_reg <= '0;
            end
            if (accept)
            begin
                have_reg      <= 1'b0;
                free_have_reg <= 1'b0;
            end
            else
            begin
                if (match && !have_reg)
                begin
                    have_reg <= 1'b1;
                end
                if (is_free && !free_have_reg)
                begin
                    free_have_reg <= 1'b1;
                end
            end
            if (cfg_write)
            begin
                capacity_reg  <= cfg_data;
                valid_reg     <= '0;
                occupancy_reg <= '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else
            begin
                valid_reg     <= valid_next;
                occupancy_reg <= occupancy_next;
                rank_reg      <= rank_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        q_idx_reg <= scan_reg;
        if (accept)
        begin
            cmd_reg <= command;
            key_reg <= key;
            val_reg <= value;
        end
        if (match && !have_reg)
        begin
            found_reg     <= q_idx_reg;
            found_val_reg <= rd_value;
        end
        if (is_old)
        begin
            old_idx_reg <= q_idx_reg;
            old_key_reg <= rd_key;
        end
        if (is_free && !free_have_reg)
        begin
            free_idx_reg <= q_idx_reg;
        end
        if (state_reg == ST_FIN)
        begin
            hit_reg <= hit_next;
            rd_reg  <= rd_next;
            ev_reg  <= ev_next;
            evk_reg <= evk_next;
            ign_reg <= ign_next;
        end
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign read_value  = rd_reg;
    assign evicted     = ev_reg;
    assign evicted_key = evk_reg;
    assign ignored     = ign_reg;

    a_fin_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |=> (done && !busy))
        else $error("done strobe missing after write-back");

    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted))
        else $error("hit and eviction in one transaction");

    a_ignored_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (done && ignored) |-> (!hit && !evicted && $past(cap_eff == '0)))
        else $error("ignored put with side effects");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occupancy_reg <= cap_eff)
        else $error("occupancy above capacity");

    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ($countones(valid_reg) == 32'(occupancy_reg)))
        else $error("valid marks disagree with occupancy");

endmodule
`default_nettype wire
